// File: rtl/lpfa_pkg.sv
// shared types and constants for the length-prefixed frame assembler
`timescale 1ns / 1ps

package lpfa_pkg;

  localparam int unsigned LEN_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STAT_W = 3;

  localparam logic [LEN_W-1:0] MAX_MESSAGE_BYTES_RESET = 32'd1048576;

  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STATUS_HEADER  = 3'd0,
    STATUS_PAYLOAD = 3'd1,
    STATUS_REFUSED = 3'd2,
    STATUS_LENERR  = 3'd3,
    STATUS_RESTART = 3'd4
  } status_t;

endpackage

// File: rtl/lpfa_if.sv
// valid/ready channel interfaces for input bytes and results
`timescale 1ns / 1ps

interface lpfa_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [lpfa_pkg::BYTE_W-1:0]   data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface lpfa_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpfa_pkg::STAT_W-1:0]   status;
  logic [lpfa_pkg::BYTE_W-1:0]   payload_byte;
  logic                          last_of_message;
  logic [lpfa_pkg::LEN_W-1:0]    message_length;

  modport source (output valid, output status, output payload_byte,
                  output last_of_message, output message_length, input ready);
  modport sink (input valid, input status, input payload_byte,
                input last_of_message, input message_length, output ready);
endinterface

// File: rtl/length_prefixed_frame_assembler_unit.sv
// length-prefixed frame assembler top level
`timescale 1ns / 1ps

// Takes one stream byte and returns one registered result per transfer, at
// one byte per cycle while results are taken. The first HEADER_BYTES bytes
// build a big-endian 32-bit length; the following bytes pass out as payload,
// the last one marked. After a complete message bytes are refused, and a
// length above max_message_bytes holds a length error, until a restart
// transfer. The rate is set by the single output register: a new byte is
// taken whenever that register is empty or is being drained in the same
// cycle. max_message_bytes is written through cfg_wr_en / cfg_wr_data; the
// user must write it only while the block is idle; no check enforces this.
module length_prefixed_frame_assembler_unit #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [lpfa_pkg::LEN_W-1:0]  cfg_wr_data,
  lpfa_in_if.sink                     bytes,
  lpfa_out_if.source                  results
);

  localparam int unsigned HC_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam logic [HC_W-1:0] HC_LAST = HC_W'(HEADER_BYTES - 1);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DONE    = 2'd2,
    PH_ERROR   = 2'd3
  } phase_t;

  phase_t                      phase;
  phase_t                      phase_next;
  logic [HC_W-1:0]             header_count;
  logic [HC_W-1:0]             header_count_next;
  logic [lpfa_pkg::LEN_W-1:0]  length_word;
  logic [lpfa_pkg::LEN_W-1:0]  length_word_next;
  logic [lpfa_pkg::LEN_W-1:0]  payload_count;
  logic [lpfa_pkg::LEN_W-1:0]  payload_count_next;
  logic [lpfa_pkg::LEN_W-1:0]  max_message_bytes;

  logic                        out_valid;
  lpfa_pkg::status_t           status;
  lpfa_pkg::status_t           status_next;
  logic [lpfa_pkg::BYTE_W-1:0] payload_byte;
  logic [lpfa_pkg::BYTE_W-1:0] payload_byte_next;
  logic                        last_of_message;
  logic                        last_next;
  logic [lpfa_pkg::LEN_W-1:0]  message_length;
  logic [lpfa_pkg::LEN_W-1:0]  message_length_next;

  logic [lpfa_pkg::LEN_W-1:0]  shifted;
  logic [lpfa_pkg::LEN_W-1:0]  count_inc;
  logic                        accept;

  assign bytes.ready = !out_valid || results.ready;
  assign accept      = bytes.valid && bytes.ready;

  assign shifted   = {length_word[lpfa_pkg::LEN_W-lpfa_pkg::BYTE_W-1:0], bytes.data_byte};
  assign count_inc = payload_count + 32'd1;

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    length_word_next    = length_word;
    payload_count_next  = payload_count;
    status_next         = lpfa_pkg::STATUS_HEADER;
    payload_byte_next   = '0;
    last_next           = 1'b0;
    message_length_next = '0;
    if (bytes.op == lpfa_pkg::OP_RESTART) begin
      phase_next         = PH_HEADER;
      header_count_next  = '0;
      length_word_next   = '0;
      payload_count_next = '0;
      status_next        = lpfa_pkg::STATUS_RESTART;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          length_word_next = shifted;
          if (header_count == HC_LAST) begin
            payload_count_next = '0;
            if (shifted > max_message_bytes) begin
              phase_next          = PH_ERROR;
              status_next         = lpfa_pkg::STATUS_LENERR;
              message_length_next = shifted;
            end else if (shifted == '0) begin
              phase_next = PH_DONE;
              last_next  = 1'b1;
            end else begin
              phase_next          = PH_PAYLOAD;
              message_length_next = shifted;
            end
          end else begin
            header_count_next = header_count + 1'b1;
          end
        end
        PH_PAYLOAD: begin
          payload_count_next  = count_inc;
          status_next         = lpfa_pkg::STATUS_PAYLOAD;
          payload_byte_next   = bytes.data_byte;
          message_length_next = length_word;
          if (count_inc >= length_word) begin
            phase_next = PH_DONE;
            last_next  = 1'b1;
          end
        end
        PH_DONE: begin
          status_next         = lpfa_pkg::STATUS_REFUSED;
          message_length_next = length_word;
        end
        PH_ERROR: begin
          status_next         = lpfa_pkg::STATUS_LENERR;
          message_length_next = length_word;
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      header_count      <= '0;
      length_word       <= '0;
      payload_count     <= '0;
      max_message_bytes <= lpfa_pkg::MAX_MESSAGE_BYTES_RESET;
      out_valid         <= 1'b0;
      status            <= lpfa_pkg::STATUS_HEADER;
      payload_byte      <= '0;
      last_of_message   <= 1'b0;
      message_length    <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_message_bytes <= cfg_wr_data;
      end
      if (accept) begin
        phase           <= phase_next;
        header_count    <= header_count_next;
        length_word     <= length_word_next;
        payload_count   <= payload_count_next;
        out_valid       <= 1'b1;
        status          <= status_next;
        payload_byte    <= payload_byte_next;
        last_of_message <= last_next;
        message_length  <= message_length_next;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign results.valid           = out_valid;
  assign results.status          = status;
  assign results.payload_byte    = payload_byte;
  assign results.last_of_message = last_of_message;
  assign results.message_length  = message_length;

endmodule
